FILE: rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Types, constants and the microcode program of the sorted table search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int DATA_W     = 32;
   localparam int IDX_IN_W   = 4;
   localparam int POS_W      = 4;
   localparam int EU_W       = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [EU_W-1:0]      EU_RESET         = 5'd16;
   localparam logic                 CMD_LOAD         = 1'b0;
   localparam logic                 CMD_SEARCH       = 1'b1;
   localparam logic [REG_IDX_W-1:0] REG_ENTRIES_USED = 1'b0;

   typedef logic [1:0] step_type;

   localparam step_type STEP_WAIT    = 2'd0;
   localparam step_type STEP_CHECK   = 2'd1;
   localparam step_type STEP_COMPARE = 2'd2;
   localparam step_type STEP_DONE    = 2'd3;

   typedef enum logic [1:0] {
      COND_SEARCH_ACC,
      COND_EMPTY,
      COND_HIT,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     take_req;
      logic     rd_en;
      logic     cmp_en;
      logic     emit;
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
   } ucode_type;

   typedef struct packed {
      logic take_req;
      logic rd_en;
      logic cmp_en;
      logic emit;
   } ctrl_type;

   typedef struct packed {
      logic search_acc;
      logic empty;
      logic hit;
      logic out_free;
   } stat_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uc;
      case (step)
         STEP_WAIT: begin
            uc = '{1'b1, 1'b0, 1'b0, 1'b0, COND_SEARCH_ACC, STEP_CHECK, STEP_WAIT};
         end
         STEP_CHECK: begin
            uc = '{1'b0, 1'b1, 1'b0, 1'b0, COND_EMPTY, STEP_DONE, STEP_COMPARE};
         end
         STEP_COMPARE: begin
            uc = '{1'b0, 1'b0, 1'b1, 1'b0, COND_HIT, STEP_DONE, STEP_CHECK};
         end
         STEP_DONE: begin
            uc = '{1'b0, 1'b0, 1'b0, 1'b1, COND_OUT_FREE, STEP_WAIT, STEP_DONE};
         end
         default: begin
            uc = '{1'b0, 1'b0, 1'b0, 1'b0, COND_OUT_FREE, STEP_WAIT, STEP_WAIT};
         end
      endcase
      return uc;
   endfunction

endpackage

FILE: rtl/core/stbs_if.sv
// ----------------------------------------------------------------------------
// stbs_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface stbs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic [stbs_pkg::IDX_IN_W-1:0]       entry_index;
   logic signed [stbs_pkg::DATA_W-1:0]  value;

   modport source (output valid, output cmd, output entry_index, output value, input ready);
   modport sink   (input valid, input cmd, input entry_index, input value, output ready);
endinterface

interface stbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [stbs_pkg::POS_W-1:0]   position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

FILE: rtl/core/stbs_csr.sv
// ----------------------------------------------------------------------------
// stbs_csr
// APB-style register block holding the entries_used register.
// ----------------------------------------------------------------------------
module stbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [stbs_pkg::EU_W-1:0]           entries_used
);

   logic [stbs_pkg::EU_W-1:0] eu_ff;
   logic [stbs_pkg::EU_W-1:0] eu_in;
   logic                      sel_eu;
   logic                      wr_en;

   assign sel_eu = (paddr[stbs_pkg::CSR_ADDR_W-1:2] == stbs_pkg::REG_ENTRIES_USED);
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      eu_in = eu_ff;
      if (wr_en && sel_eu) begin
         eu_in = pwdata[stbs_pkg::EU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eu_ff <= stbs_pkg::EU_RESET;
      end else begin
         eu_ff <= eu_in;
      end
   end

   assign prdata       = sel_eu ? stbs_pkg::CSR_DATA_W'(eu_ff) : '0;
   assign pready       = 1'b1;
   assign entries_used = eu_ff;

endmodule

FILE: rtl/core/stbs_useq.sv
// ----------------------------------------------------------------------------
// stbs_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module stbs_useq (
   input  logic                 clock,
   input  logic                 reset,
   input  stbs_pkg::stat_type   stat,
   output stbs_pkg::ctrl_type   ctrl
);

   stbs_pkg::step_type  step_ff;
   stbs_pkg::step_type  step_in;
   stbs_pkg::ucode_type uc;
   logic                cond_true;

   assign uc = stbs_pkg::ucode_rom(step_ff);

   always_comb begin
      case (uc.cond)
         stbs_pkg::COND_SEARCH_ACC: cond_true = stat.search_acc;
         stbs_pkg::COND_EMPTY:      cond_true = stat.empty;
         stbs_pkg::COND_HIT:        cond_true = stat.hit;
         stbs_pkg::COND_OUT_FREE:   cond_true = stat.out_free;
         default:                   cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in = cond_true ? uc.tgt_true : uc.tgt_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= stbs_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl.take_req = uc.take_req;
      ctrl.rd_en    = uc.rd_en;
      ctrl.cmp_en   = uc.cmp_en & ~stat.empty;
      ctrl.emit     = uc.emit & stat.out_free;
   end

endmodule

FILE: rtl/core/stbs_datapath.sv
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search bounds, key compare and response register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [stbs_pkg::EU_W-1:0]     entries_used,
   input  stbs_pkg::ctrl_type            ctrl,
   output stbs_pkg::stat_type            stat,
   stbs_req_if.sink                      req,
   stbs_rsp_if.source                    rsp
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SAT_W = (CNT_W > stbs_pkg::EU_W) ? CNT_W : stbs_pkg::EU_W;
   localparam int LD_W  = (CNT_W > stbs_pkg::IDX_IN_W) ? CNT_W : stbs_pkg::IDX_IN_W;
   localparam int PX_W  = (CNT_W > stbs_pkg::POS_W) ? CNT_W : stbs_pkg::POS_W;

   logic [stbs_pkg::DATA_W-1:0]        table_ff [TABLE_DEPTH];
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [stbs_pkg::DATA_W-1:0] key_ff;
   logic signed [stbs_pkg::DATA_W-1:0] key_in;
   logic [CNT_W-1:0]                   lo_ff;
   logic [CNT_W-1:0]                   lo_in;
   logic [CNT_W-1:0]                   hp1_ff;
   logic [CNT_W-1:0]                   hp1_in;
   logic [CNT_W-1:0]                   mid_ff;
   logic [CNT_W-1:0]                   mid_in;
   logic                               found_ff;
   logic                               found_in;
   logic [stbs_pkg::POS_W-1:0]         pos_ff;
   logic [stbs_pkg::POS_W-1:0]         pos_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               rsp_found_ff;
   logic                               rsp_found_in;
   logic [stbs_pkg::POS_W-1:0]         rsp_pos_ff;
   logic [stbs_pkg::POS_W-1:0]         rsp_pos_in;

   logic                               req_acc;
   logic                               search_acc;
   logic                               load_acc;
   logic [SAT_W-1:0]                   eu_ext;
   logic [SAT_W-1:0]                   n_sat;
   logic [CNT_W-1:0]                   n_cnt;
   logic [LD_W-1:0]                    ld_idx_ext;
   logic                               ld_ok;
   logic [IDX_W-1:0]                   ld_addr;
   logic [CNT_W:0]                     mid_sum;
   logic [CNT_W-1:0]                   mid_calc;
   logic [IDX_W-1:0]                   rd_addr;
   logic [CNT_W-1:0]                   mid_p1;
   logic [PX_W-1:0]                    mid_pos_ext;
   logic                               empty;
   logic                               hit;
   logic                               less;
   logic                               out_free;

   assign req.ready  = ctrl.take_req & ~reset;
   assign req_acc    = req.valid & req.ready;
   assign search_acc = req_acc & (req.cmd == stbs_pkg::CMD_SEARCH);
   assign load_acc   = req_acc & (req.cmd == stbs_pkg::CMD_LOAD);

   assign eu_ext = SAT_W'(entries_used);
   assign n_sat  = (eu_ext > SAT_W'(TABLE_DEPTH)) ? SAT_W'(TABLE_DEPTH) : eu_ext;
   assign n_cnt  = n_sat[CNT_W-1:0];

   assign ld_idx_ext = LD_W'(req.entry_index);
   assign ld_ok      = ld_idx_ext < LD_W'(TABLE_DEPTH);
   assign ld_addr    = ld_idx_ext[IDX_W-1:0];

   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hp1_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid_calc    = mid_sum[CNT_W:1];
   assign rd_addr     = mid_calc[IDX_W-1:0];
   assign mid_p1      = mid_ff + {{(CNT_W-1){1'b0}}, 1'b1};
   assign mid_pos_ext = PX_W'(mid_ff);

   assign empty    = (lo_ff >= hp1_ff);
   assign hit      = (rd_data_ff == key_ff);
   assign less     = (rd_data_ff < key_ff);
   assign out_free = ~rsp_valid_ff | rsp.ready;

   always_comb begin
      stat.search_acc = search_acc;
      stat.empty      = empty;
      stat.hit        = hit;
      stat.out_free   = out_free;
   end

   always_comb begin
      key_in   = search_acc ? req.value : key_ff;
      lo_in    = lo_ff;
      hp1_in   = hp1_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      mid_in   = ctrl.rd_en ? mid_calc : mid_ff;
      if (search_acc) begin
         lo_in    = '0;
         hp1_in   = n_cnt;
         found_in = 1'b0;
      end else if (ctrl.cmp_en) begin
         if (hit) begin
            found_in = 1'b1;
            pos_in   = mid_pos_ext[stbs_pkg::POS_W-1:0];
         end else if (less) begin
            lo_in = mid_p1;
         end else begin
            hp1_in = mid_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_pos_in   = found_ff ? pos_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && ld_ok) begin
         table_ff[ld_addr] <= req.value;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hp1_ff       <= hp1_in;
      mid_ff       <= mid_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = rsp_found_ff;
   assign rsp.position = rsp_pos_ff;

endmodule

FILE: rtl/core/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Load: words are taken back to back while the sequencer waits. Search: the
// accept step, then P probes (at most floor(log2(N))+1), then the response;
// each probe does a registered table read (check step), then the compare.
// One word is worked on at a time; a finished response waits in its register.
// Reset clears the sequencer and response valid, entries_used returns to 16;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   stbs_req_if.sink                            req_ch,
   stbs_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [stbs_pkg::EU_W-1:0] entries_used;
   stbs_pkg::ctrl_type        ctrl;
   stbs_pkg::stat_type        stat;

   stbs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .entries_used (entries_used)
   );

   stbs_useq u_useq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .entries_used (entries_used),
      .ctrl         (ctrl),
      .stat         (stat),
      .req          (req_ch),
      .rsp          (rsp_ch)
   );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted table binary search core. It loads sorted
// and partly unsorted tables, runs searches while both channels idle and stall
// at random, and checks every response word against a binary search over the
// bench's own copy of the table. It also checks the entries_used register
// through the register port.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TABLE_DEPTH  = 16;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 100;

   localparam logic [stbs_pkg::REG_IDX_W-1:0]     REG_UNMAPPED = 1'b1;
   localparam logic signed [stbs_pkg::DATA_W-1:0] VALUE_MIN    = 32'sh8000_0000;
   localparam logic signed [stbs_pkg::DATA_W-1:0] VALUE_MAX    = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic                               cmd;
      logic [stbs_pkg::IDX_IN_W-1:0]      entry_index;
      logic signed [stbs_pkg::DATA_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic                       found;
      logic [stbs_pkg::POS_W-1:0] position;
   } match_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [stbs_pkg::CSR_ADDR_W-1:0] paddr;
   logic [stbs_pkg::CSR_DATA_W-1:0] pwdata;
   logic [stbs_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   stbs_req_if req_bus ();
   stbs_rsp_if rsp_bus ();

   sorted_table_binary_search_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   req_word_type                       pending_words[$];
   match_type                          expected_matches[$];
   logic signed [stbs_pkg::DATA_W-1:0] entry_mirror [TABLE_DEPTH];
   logic signed [stbs_pkg::DATA_W-1:0] staged_table [TABLE_DEPTH];
   logic [stbs_pkg::EU_W-1:0]          entries_cfg = stbs_pkg::EU_RESET;

   int words_accepted   = 0;
   int loads_accepted   = 0;
   int searches_accepted = 0;
   int hits_expected    = 0;
   int rsp_seen         = 0;
   int mismatch_count   = 0;
   int settings_used    = 0;
   int cycle_count      = 0;

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic match_type search_mirror(input logic signed [stbs_pkg::DATA_W-1:0] key);
      match_type m;
      int        lo;
      int        hi;
      int        mid;
      m  = '0;
      lo = 0;
      hi = ((entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg)) - 1;
      while (lo <= hi && !m.found) begin
         mid = (lo + hi) / 2;
         if (entry_mirror[mid] == key) begin
            m.found    = 1'b1;
            m.position = mid[stbs_pkg::POS_W-1:0];
         end else if (entry_mirror[mid] < key) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return m;
   endfunction

   // request driver: bursts of words with random gaps
   req_word_type on_bus;
   int           burst_left;
   int           gap_left;

   always @(posedge clock) begin : drive_req
      match_type m;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 4;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            words_accepted++;
            if (on_bus.cmd == stbs_pkg::CMD_LOAD) begin
               entry_mirror[on_bus.entry_index] = on_bus.value;
               loads_accepted++;
            end else begin
               m = search_mirror(on_bus.value);
               expected_matches.push_back(m);
               searches_accepted++;
               if (m.found) hits_expected++;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               on_bus = pending_words.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.cmd         <= on_bus.cmd;
               req_bus.entry_index <= on_bus.entry_index;
               req_bus.value       <= on_bus.value;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // response ready: windows of stall patterns, plus a long hold now and then
   int hold_left;
   int window_left;
   int stall_mode;
   int next_hold_at;

   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left    = 0;
         window_left  = 0;
         stall_mode   = 0;
         next_hold_at = 150;
      end else begin
         if (rsp_seen >= next_hold_at) begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + 450;
         end
         if (window_left == 0) begin
            window_left = $urandom_range(20, 80);
            stall_mode  = $urandom_range(0, 3);
         end
         window_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      match_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (expected_matches.size() == 0) begin
            flag_error($sformatf("unexpected response found=%0b position=%0d",
                                 rsp_bus.found, rsp_bus.position));
         end else begin
            want = expected_matches.pop_front();
            if (rsp_bus.found !== want.found || rsp_bus.position !== want.position)
               flag_error($sformatf({"response %0d: expected found=%0b position=%0d, ",
                                     "got found=%0b position=%0d"},
                                    rsp_seen, want.found, want.position,
                                    rsp_bus.found, rsp_bus.position));
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ERROR: run stopped after %0d cycles, %0d words queued, %0d responses outstanding",
               cycle_count, pending_words.size(), expected_matches.size());
      $display("Mismatches found");
      $finish;
   end

   task automatic queue_load(input int idx, input logic signed [stbs_pkg::DATA_W-1:0] val);
      req_word_type w;
      w.cmd         = stbs_pkg::CMD_LOAD;
      w.entry_index = idx[stbs_pkg::IDX_IN_W-1:0];
      w.value       = val;
      staged_table[idx] = val;
      pending_words.push_back(w);
   endtask

   task automatic queue_search(input logic signed [stbs_pkg::DATA_W-1:0] key);
      req_word_type w;
      int           idx;
      idx           = $urandom_range(0, TABLE_DEPTH - 1);
      w.cmd         = stbs_pkg::CMD_SEARCH;
      w.entry_index = idx[stbs_pkg::IDX_IN_W-1:0];
      w.value       = key;
      pending_words.push_back(w);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_matches.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic [stbs_pkg::REG_IDX_W-1:0] idx,
                            input logic [stbs_pkg::CSR_DATA_W-1:0] wdata,
                            output logic [stbs_pkg::CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock);
      while (pready !== 1'b1);
      rdata = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_reg(input logic [stbs_pkg::REG_IDX_W-1:0] idx,
                              input logic [stbs_pkg::CSR_DATA_W-1:0] wdata);
      logic [stbs_pkg::CSR_DATA_W-1:0] rdata;
      wait_idle();
      csr_cycle(1'b1, idx, wdata, rdata);
      if (idx == stbs_pkg::REG_ENTRIES_USED) entries_cfg = wdata[stbs_pkg::EU_W-1:0];
      settings_used++;
      csr_cycle(1'b0, stbs_pkg::REG_ENTRIES_USED, '0, rdata);
      if (rdata !== stbs_pkg::CSR_DATA_W'(entries_cfg))
         flag_error($sformatf("entries_used read: expected %0d, got %0d", entries_cfg, rdata));
   endtask

   // ascending table, from small steps with duplicates to a wide spread
   task automatic refill_table();
      logic signed [stbs_pkg::DATA_W-1:0] vals [TABLE_DEPTH];
      longint                             step_max;
      longint                             span;
      longint                             level;
      logic                               descending;
      case ($urandom_range(0, 3))
         0: step_max = 2;
         1: step_max = 300;
         2: step_max = 64'd1 << 20;
         default: step_max = 64'd1 << 27;
      endcase
      span       = 64'd4294967295 - 16 * step_max;
      level      = (longint'($urandom) % (span + 1)) - 64'sd2147483648;
      descending = ($urandom_range(0, 1) == 1);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         level   = level + longint'($urandom_range(0, int'(step_max)));
         vals[i] = level[stbs_pkg::DATA_W-1:0];
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (descending) queue_load(TABLE_DEPTH - 1 - i, vals[TABLE_DEPTH - 1 - i]);
         else queue_load(i, vals[i]);
   endtask

   initial begin : stimulus
      logic [stbs_pkg::CSR_DATA_W-1:0]    wdata;
      logic signed [stbs_pkg::DATA_W-1:0] key;
      logic signed [stbs_pkg::DATA_W-1:0] pick;
      int                                 used;
      int                                 sel;
      int                                 eu;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = stbs_pkg::CMD_LOAD;
      req_bus.entry_index = '0;
      req_bus.value       = '0;
      rsp_bus.ready       = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: full ramp with both extremes, then hits, misses and edge settings
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (i == 0) queue_load(i, VALUE_MIN);
         else if (i == TABLE_DEPTH - 1) queue_load(i, VALUE_MAX);
         else queue_load(i, (i - 8) * (i - 8) * (i - 8) * 65536);
      queue_search(VALUE_MIN);
      queue_search(VALUE_MAX);
      queue_search(0);
      queue_search(1);
      queue_search(VALUE_MIN + 1);

      program_reg(stbs_pkg::REG_ENTRIES_USED, 32'h0000_0000);
      queue_search(0);
      program_reg(stbs_pkg::REG_ENTRIES_USED, 32'hFFFF_FFFF);
      queue_search(VALUE_MAX);
      program_reg(stbs_pkg::REG_ENTRIES_USED, 32'h0000_0001);
      queue_search(VALUE_MIN);
      program_reg(REG_UNMAPPED, 32'h0000_0005);
      program_reg(stbs_pkg::REG_ENTRIES_USED, 32'hFFFF_FFF0);
      // break the order: the middle probe now shadows the key at entry 8
      queue_load(7, VALUE_MAX);
      queue_search(VALUE_MAX);
      queue_search(0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: eu = 16;
            1: eu = 1;
            2: eu = 0;
            3: eu = 31;
            4: eu = 17;
            5: eu = 2;
            6: eu = 15;
            default: eu = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16);
         endcase
         wdata                     = $urandom;
         wdata[stbs_pkg::EU_W-1:0] = eu[stbs_pkg::EU_W-1:0];
         program_reg(stbs_pkg::REG_ENTRIES_USED, wdata);
         used = (eu > TABLE_DEPTH) ? TABLE_DEPTH : ((eu < 1) ? 1 : eu);
         refill_table();
         for (int k = 0; k < PHASE_WORDS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
               refill_table();
            end else if (sel < 10) begin
               queue_load($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else begin
               pick = staged_table[$urandom_range(0, used - 1)];
               sel  = $urandom_range(0, 9);
               if (sel < 5) key = pick;
               else if (sel < 7) key = $urandom_range(0, 1) ? pick + 1 : pick - 1;
               else if (sel < 9) key = $urandom;
               else key = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
               queue_search(key);
            end
         end
      end

      wait_idle();
      $display("Summary: %0d words (%0d loads, %0d searches, %0d expected hits)",
               words_accepted, loads_accepted, searches_accepted, hits_expected);
      $display("Summary: %0d register writes, %0d responses checked in %0d cycles",
               settings_used, rsp_seen, cycle_count);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
